// ===== src/lps_pkg.sv =====
package lps_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE_EVERY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_AVG      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_AVG       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MODE    = 3'd4;

    // register reset values
    localparam logic [9:0]         RST_ADVANCE_EVERY = 10'd50;
    localparam logic [5:0]         RST_WINDOW_LEN    = 6'd10;
    localparam logic signed [15:0] RST_HIGH_AVG      = 16'sd3500;
    localparam logic signed [15:0] RST_LOW_AVG       = 16'sd1500;
    localparam logic [2:0]         RST_START_MODE    = 3'd1;

    // request types
    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // mode codes
    localparam logic [2:0] MODE_OFF       = 3'd0;
    localparam logic [2:0] MODE_SLOW      = 3'd1;
    localparam logic [2:0] MODE_FAST      = 3'd2;
    localparam logic [2:0] MODE_HEARTBEAT = 3'd3;
    localparam logic [2:0] MODE_SOS       = 3'd4;
    localparam logic [2:0] MODE_RAINBOW   = 3'd5;
    localparam logic [3:0] NUM_MODES      = 4'd6;

    // periods in ms
    localparam logic [10:0] PER_RESET     = 11'd500;
    localparam logic [10:0] PER_OFF       = 11'd1000;
    localparam logic [10:0] PER_SLOW      = 11'd1000;
    localparam logic [10:0] PER_FAST      = 11'd200;
    localparam logic [10:0] PER_HEARTBEAT = 11'd100;
    localparam logic [10:0] PER_SOS_DOT   = 11'd200;
    localparam logic [10:0] PER_SOS_DASH  = 11'd600;
    localparam logic [10:0] PER_SOS_GAP   = 11'd1000;
    localparam logic [10:0] PER_RAINBOW   = 11'd300;

    // heartbeat: third LED lit on these steps of ten
    localparam logic [3:0] HB_STEPS  = 4'd10;
    localparam logic [9:0] HB_ON_MAP = 10'b00_0001_1011;

    // SOS "...---...": bit set means dot
    localparam logic [3:0] SOS_LEN     = 4'd9;
    localparam logic [8:0] SOS_DOT_MAP = 9'b111_000_111;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] sample_value;
        logic               sample_valid;
    } t_in_item;

    typedef struct packed {
        logic        led_first;
        logic        led_second;
        logic        led_third;
        logic [2:0]  mode;
        logic        mode_changed;
        logic [10:0] period_ms;
    } t_out_item;

    typedef struct packed {
        logic [9:0]         advance_every;
        logic [5:0]         window_len;
        logic signed [15:0] high_avg;
        logic signed [15:0] low_avg;
        logic               start_wr;
        logic [2:0]         start_val;
    } t_cfg;

endpackage

// ===== src/led_pattern_sequencer_core.sv =====
// Channel   Direction  Handshake                        Payload
// input     in         i_in_valid / o_in_stall          i_in_data  (t_in_item)
// output    out        o_out_valid / i_out_stall        o_out_data (t_out_item)
// config    in         i_cfg_we, i_cfg_idx              i_cfg_data (16 bit)
//
// One item per cycle while the output is not stalled: the state update and
// the result are computed in the cycle of the transfer and the result lands
// in the output register.
// Synchronous active-low reset; state returns to its power-up values.
// A result held by a stalled consumer blocks input only while the output
// register is full and the consumer stalls.
module led_pattern_sequencer_core
    import lps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input
    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    output logic                  o_in_stall,
    // result output
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_stall,
    // register writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      w_cfg;
    t_out_item w_result;
    logic      w_take;
    logic      r_out_valid;
    t_out_item r_out_data;

    lps_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // input transfer whenever the output register is free or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_take     = i_in_valid && !o_in_stall;

    lps_update u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_take   (w_take),
        .i_item   (i_in_data),
        .o_result (w_result)
    );

    // output register: every accepted item yields exactly one result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== src/lps_cfg_regs.sv =====
module lps_cfg_regs
    import lps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [9:0]         r_advance_every;
    logic [5:0]         r_window_len;
    logic signed [15:0] r_high_avg;
    logic signed [15:0] r_low_avg;
    logic [2:0]         r_start_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_advance_every <= RST_ADVANCE_EVERY;
            r_window_len    <= RST_WINDOW_LEN;
            r_high_avg      <= RST_HIGH_AVG;
            r_low_avg       <= RST_LOW_AVG;
            r_start_mode    <= RST_START_MODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ADVANCE_EVERY: r_advance_every <= i_cfg_data[9:0];
                CFG_WINDOW_LEN:    r_window_len    <= i_cfg_data[5:0];
                CFG_HIGH_AVG:      r_high_avg      <= $signed(i_cfg_data);
                CFG_LOW_AVG:       r_low_avg       <= $signed(i_cfg_data);
                CFG_START_MODE:    r_start_mode    <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // start_mode write restarts the pattern in the same cycle
    assign o_cfg.advance_every = r_advance_every;
    assign o_cfg.window_len    = r_window_len;
    assign o_cfg.high_avg      = r_high_avg;
    assign o_cfg.low_avg       = r_low_avg;
    assign o_cfg.start_wr      = i_rst_n && i_cfg_we && (i_cfg_idx == CFG_START_MODE);
    assign o_cfg.start_val     = (o_cfg.start_wr) ? i_cfg_data[2:0] : r_start_mode;

endmodule

// ===== src/lps_update.sv =====
module lps_update
    import lps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_take,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic [2:0]         r_mode,   n_mode;
    logic [3:0]         r_step,   n_step;
    logic               r_blink,  n_blink;
    logic [3:0]         r_sos,    n_sos;
    logic [9:0]         r_exp,    n_exp;
    logic [10:0]        r_period, n_period;
    logic [10:0]        r_cd,     n_cd;
    logic [2:0]         r_led,    n_led;
    logic signed [21:0] r_sum,    n_sum;
    logic [5:0]         r_cnt,    n_cnt;
    logic               n_changed;

    logic [3:0]         w_hb_s;
    logic [3:0]         w_hb_inc;
    logic [3:0]         w_sos_s;
    logic [3:0]         w_sos_inc;
    logic               w_dot;
    logic [3:0]         w_mode_inc;
    logic [2:0]         w_next_mode;
    logic signed [21:0] w_sum_inc;
    logic [5:0]         w_cnt_inc;
    logic signed [22:0] w_high_lim;
    logic signed [22:0] w_low_lim;
    logic signed [22:0] w_sum_ext;

    assign w_hb_s    = (r_step >= HB_STEPS) ? r_step - HB_STEPS : r_step;
    assign w_hb_inc  = w_hb_s + 4'd1;
    assign w_sos_s   = (r_sos < SOS_LEN) ? r_sos : 4'd0;
    assign w_sos_inc = w_sos_s + 4'd1;
    assign w_dot     = SOS_DOT_MAP[w_sos_s];

    // (mode + 1) mod 6, also from the unused codes
    assign w_mode_inc  = {1'b0, r_mode} + 4'd1;
    assign w_next_mode = (w_mode_inc >= NUM_MODES) ? 3'(w_mode_inc - NUM_MODES)
                                                   : w_mode_inc[2:0];

    assign w_sum_inc  = r_sum + 22'(i_item.sample_value);
    assign w_cnt_inc  = r_cnt + 6'd1;
    assign w_sum_ext  = 23'(w_sum_inc);
    assign w_high_lim = 23'(i_cfg.high_avg) * 23'($signed({1'b0, w_cnt_inc}));
    assign w_low_lim  = 23'(i_cfg.low_avg) * 23'($signed({1'b0, w_cnt_inc}));

    always_comb begin
        n_mode    = r_mode;
        n_step    = r_step;
        n_blink   = r_blink;
        n_sos     = r_sos;
        n_exp     = r_exp;
        n_period  = r_period;
        n_cd      = r_cd;
        n_led     = r_led;
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        n_changed = 1'b0;
        if (i_cfg.start_wr) begin
            n_mode  = i_cfg.start_val;
            n_step  = '0;
            n_blink = 1'b0;
            n_cd    = r_period;
        end else if (i_take) begin
            if (i_item.req_type == REQ_TICK) begin
                if (r_cd > 11'd1) begin
                    n_cd = r_cd - 11'd1;
                end else begin
                    unique case (r_mode)
                        MODE_OFF: begin
                            n_led    = 3'b000;
                            n_period = PER_OFF;
                        end
                        MODE_SLOW: begin
                            n_blink  = ~r_blink;
                            n_led    = {2'b00, ~r_blink};
                            n_period = PER_SLOW;
                        end
                        MODE_FAST: begin
                            n_blink  = ~r_blink;
                            n_led    = {1'b0, ~r_blink, 1'b0};
                            n_period = PER_FAST;
                        end
                        MODE_HEARTBEAT: begin
                            n_led    = {HB_ON_MAP[w_hb_s], 2'b00};
                            n_step   = (w_hb_inc >= HB_STEPS) ? 4'd0 : w_hb_inc;
                            n_period = PER_HEARTBEAT;
                        end
                        MODE_SOS: begin
                            n_led    = {3{w_dot}};
                            n_period = w_dot ? PER_SOS_DOT : PER_SOS_DASH;
                            n_sos    = w_sos_inc;
                            if (w_sos_inc >= SOS_LEN) begin
                                n_sos    = 4'd0;
                                n_period = n_period + PER_SOS_GAP;
                            end
                        end
                        MODE_RAINBOW: begin
                            n_led    = r_step[2:0];
                            n_step   = {1'b0, r_step[2:0] + 3'd1};
                            n_period = PER_RAINBOW;
                        end
                        default: begin
                            n_led = 3'b000;
                        end
                    endcase
                    n_cd  = n_period;
                    n_exp = r_exp + 10'd1;
                    if (n_exp >= i_cfg.advance_every) begin
                        n_exp     = '0;
                        n_mode    = w_next_mode;
                        n_step    = '0;
                        n_blink   = 1'b0;
                        n_changed = 1'b1;
                    end
                end
            end else if (i_item.sample_valid) begin
                n_sum = w_sum_inc;
                n_cnt = w_cnt_inc;
                if (w_cnt_inc >= i_cfg.window_len) begin
                    if (w_sum_ext > w_high_lim) begin
                        n_mode    = MODE_FAST;
                        n_step    = '0;
                        n_blink   = 1'b0;
                        n_cd      = r_period;
                        n_changed = 1'b1;
                    end else if (w_sum_ext < w_low_lim) begin
                        n_mode    = MODE_SOS;
                        n_step    = '0;
                        n_blink   = 1'b0;
                        n_cd      = r_period;
                        n_changed = 1'b1;
                    end
                    n_sum = '0;
                    n_cnt = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= RST_START_MODE;
            r_step   <= '0;
            r_blink  <= 1'b0;
            r_sos    <= '0;
            r_exp    <= '0;
            r_period <= PER_RESET;
            r_cd     <= PER_RESET;
            r_led    <= '0;
            r_sum    <= '0;
            r_cnt    <= '0;
        end else begin
            r_mode   <= n_mode;
            r_step   <= n_step;
            r_blink  <= n_blink;
            r_sos    <= n_sos;
            r_exp    <= n_exp;
            r_period <= n_period;
            r_cd     <= n_cd;
            r_led    <= n_led;
            r_sum    <= n_sum;
            r_cnt    <= n_cnt;
        end
    end

    assign o_result.led_first    = n_led[0];
    assign o_result.led_second   = n_led[1];
    assign o_result.led_third    = n_led[2];
    assign o_result.mode         = n_mode;
    assign o_result.mode_changed = n_changed;
    assign o_result.period_ms    = n_period;

endmodule

// ===== test/tb_led_pattern_sequencer_core.sv =====
module tb_led_pattern_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lps_pkg::*;

    // Mode codes the package leaves unnamed; the block must still handle them.
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    // setup() argument meaning "leave start_mode alone"
    localparam int NO_START = -1;
    // run limit, far above the slowest legal run
    localparam int LIMIT_NS = 1_000_000;

    // ------------------------------------------------------------------
    // Scoreboard: shadow copy of the sequencer state, expected results queue
    // ------------------------------------------------------------------
    class led_pattern_scoreboard;
        // register shadows
        logic [9:0]         advance_every;
        logic [5:0]         window_len;
        logic signed [15:0] high_avg;
        logic signed [15:0] low_avg;
        logic [2:0]         start_mode;
        // sequencer state
        logic [2:0]         cur_mode;
        logic [5:0]         step_cnt;
        logic               blink;
        logic [3:0]         sos_idx;
        logic [9:0]         expiry_cnt;
        logic [10:0]        period;
        logic [10:0]        countdown;
        logic [2:0]         leds;
        logic signed [21:0] sum;
        logic [5:0]         cnt;

        t_out_item pattern_q[$];
        int        mismatches;
        int        results_seen;

        function new();
            advance_every = RST_ADVANCE_EVERY;
            window_len    = RST_WINDOW_LEN;
            high_avg      = RST_HIGH_AVG;
            low_avg       = RST_LOW_AVG;
            start_mode    = RST_START_MODE;
            cur_mode      = RST_START_MODE;
            step_cnt      = '0;
            blink         = 1'b0;
            sos_idx       = '0;
            expiry_cnt    = '0;
            period        = PER_RESET;
            countdown     = PER_RESET;
            leds          = '0;
            sum           = '0;
            cnt           = '0;
            mismatches    = 0;
            results_seen  = 0;
        endfunction

        // sos_idx deliberately survives a restart
        function void restart(logic [2:0] m);
            cur_mode  = m;
            step_cnt  = '0;
            blink     = 1'b0;
            countdown = period;
        endfunction

        function void end_of_period();
            int s;
            bit dot;
            case (cur_mode)
                MODE_OFF: begin
                    leds   = 3'b000;
                    period = PER_OFF;
                end
                MODE_SLOW: begin
                    blink  = ~blink;
                    leds   = {2'b00, blink};
                    period = PER_SLOW;
                end
                MODE_FAST: begin
                    blink  = ~blink;
                    leds   = {1'b0, blink, 1'b0};
                    period = PER_FAST;
                end
                MODE_HEARTBEAT: begin
                    s        = step_cnt % 10;
                    leds     = (s < 2 || (s >= 3 && s < 5)) ? 3'b100 : 3'b000;
                    step_cnt = (s + 1 >= 10) ? 6'd0 : 6'(s + 1);
                    period   = PER_HEARTBEAT;
                end
                MODE_SOS: begin
                    s      = (sos_idx < SOS_LEN) ? int'(sos_idx) : 0;
                    dot    = (s < 3) || (s >= 6);
                    leds   = dot ? 3'b111 : 3'b000;
                    period = dot ? PER_SOS_DOT : PER_SOS_DASH;
                    s++;
                    if (s >= SOS_LEN) begin
                        s      = 0;
                        period = period + PER_SOS_GAP;
                    end
                    sos_idx = 4'(s);
                end
                MODE_RAINBOW: begin
                    s        = step_cnt & 7;
                    leds     = 3'(s);
                    step_cnt = 6'((s + 1) & 7);
                    period   = PER_RAINBOW;
                end
                default: leds = 3'b000;   // spare codes: dark, period kept
            endcase
            countdown = period;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ADVANCE_EVERY: advance_every = data[9:0];
                CFG_WINDOW_LEN:    window_len    = data[5:0];
                CFG_HIGH_AVG:      high_avg      = data;
                CFG_LOW_AVG:       low_avg       = data;
                CFG_START_MODE: begin
                    start_mode = data[2:0];
                    restart(start_mode);
                end
                default: ;
            endcase
        endfunction

        // step the shadow sequencer by one accepted item, queue its result
        function void note_item(t_in_item it);
            t_out_item r;
            bit        changed;
            int        n;
            changed = 1'b0;
            if (it.req_type == REQ_TICK) begin
                if (countdown > 1) begin
                    countdown = countdown - 11'd1;
                end else begin
                    end_of_period();
                    expiry_cnt = expiry_cnt + 10'd1;
                    if (expiry_cnt >= advance_every) begin
                        expiry_cnt = '0;
                        restart(3'((int'(cur_mode) + 1) % 6));
                        changed = 1'b1;
                    end
                end
            end else if (it.sample_valid) begin
                sum = sum + it.sample_value;
                cnt = cnt + 6'd1;
                if (cnt >= window_len) begin
                    n = int'(cnt);
                    if (sum > high_avg * n) begin
                        restart(MODE_FAST);
                        changed = 1'b1;
                    end else if (sum < low_avg * n) begin
                        restart(MODE_SOS);
                        changed = 1'b1;
                    end
                    sum = '0;
                    cnt = '0;
                end
            end
            r.led_first    = leds[0];
            r.led_second   = leds[1];
            r.led_third    = leds[2];
            r.mode         = cur_mode;
            r.mode_changed = changed;
            r.period_ms    = period;
            pattern_q.push_back(r);
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            mismatches++;
            if (mismatches <= 100)
                $display("%0t ns: result %0d %s: got %0d, want %0d",
                         $time, results_seen, what, got, want);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (pattern_q.size() == 0) begin
                report("no result pending", 16'(got), 16'd0);
                return;
            end
            want = pattern_q.pop_front();
            if (got.led_first !== want.led_first)
                report("led_first", 16'(got.led_first), 16'(want.led_first));
            if (got.led_second !== want.led_second)
                report("led_second", 16'(got.led_second), 16'(want.led_second));
            if (got.led_third !== want.led_third)
                report("led_third", 16'(got.led_third), 16'(want.led_third));
            if (got.mode !== want.mode)
                report("mode", 16'(got.mode), 16'(want.mode));
            if (got.mode_changed !== want.mode_changed)
                report("mode_changed", 16'(got.mode_changed), 16'(want.mode_changed));
            if (got.period_ms !== want.period_ms)
                report("period_ms", 16'(got.period_ms), 16'(want.period_ms));
        endtask

        function int pending();
            return pattern_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    t_in_item              in_data;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_data;
    logic                  out_stall;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    led_pattern_sequencer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_stall(out_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    led_pattern_scoreboard sb = new();

    // idle odds in percent, per cycle; changed between phases
    int src_idle_pct;
    int snk_stall_pct;

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake hangs.
    initial begin
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    // Result side: all sampling uses pre-edge values, so the check at an edge
    // only ever sees results of items accepted at earlier edges. The stall for
    // the next cycle is drawn after the sample.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
        out_stall <= ($urandom_range(99) < snk_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_in_item make_item(input logic req, input int value,
                                           input logic valid);
        t_in_item it;
        it.req_type     = req;
        it.sample_value = 16'(value);
        it.sample_valid = valid;
        return it;
    endfunction

    // Mostly ticks so the countdown actually reaches its expiries; samples
    // hit the range ends now and then. Sample fields on ticks are junk.
    function automatic t_in_item random_item();
        t_in_item it;
        int       value;
        case ($urandom_range(9))
            0:       value = -5000;
            1:       value = 20000;
            default: value = int'($urandom_range(25000)) - 5000;
        endcase
        if ($urandom_range(99) < 92)
            it = make_item(REQ_TICK, int'($urandom_range(16'hffff)), 1'($urandom_range(1)));
        else
            it = make_item(REQ_SAMPLE, value, ($urandom_range(9) != 0));
        return it;
    endfunction

    // Present one item and hold it until a transfer. Valid is left high on
    // return; the caller follows with another send_item or with drain().
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_stall);
        sb.note_item(it);
    endtask

    // Drop valid, wait for every pending result, then cover the output
    // register latency before anything touches the registers.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // One register write per call; we goes low for a cycle in between.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.note_config(idx, data);
        @(posedge i_clk);
    endtask

    task automatic setup(input int adv, input int win, input int hi, input int lo,
                         input int start);
        drain();
        write_reg(CFG_ADVANCE_EVERY, 16'(adv));
        write_reg(CFG_WINDOW_LEN,    16'(win));
        write_reg(CFG_HIGH_AVG,      16'(hi));
        write_reg(CFG_LOW_AVG,       16'(lo));
        if (start != NO_START)
            write_reg(CFG_START_MODE, 16'(start));
    endtask

    // Invalid samples do nothing inside the block, so they are not counted.
    task automatic run_random(input int count);
        t_in_item it;
        int       done;
        done = 0;
        while (done < count) begin
            it = random_item();
            send_item(it);
            if (!(it.req_type == REQ_SAMPLE && !it.sample_valid))
                done++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        in_valid      <= 1'b0;
        in_data       <= '0;
        cfg_we        <= 1'b0;
        cfg_idx       <= '0;
        cfg_data      <= '0;
        i_rst_n       <= 1'b0;
        src_idle_pct  = 7;
        snk_stall_pct = 67;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: reset defaults, window of ten
        // sample fields on a tick are don't-care
        send_item(make_item(REQ_TICK, -5000, 1'b1));
        send_item(make_item(REQ_TICK, 20000, 1'b0));
        // invalid samples leave the averager alone
        send_item(make_item(REQ_SAMPLE, 20000, 1'b0));
        send_item(make_item(REQ_SAMPLE, -5000, 1'b0));
        // one counted sample, window not yet full
        send_item(make_item(REQ_SAMPLE, 20000, 1'b1));
        drain();

        // --- window of one: every valid sample makes a decision
        write_reg(CFG_WINDOW_LEN, 16'd1);
        send_item(make_item(REQ_SAMPLE, 20000, 1'b1));   // carries earlier sum, fast
        send_item(make_item(REQ_SAMPLE, 20000, 1'b1));   // fast again: still a restart
        send_item(make_item(REQ_SAMPLE, -5000, 1'b1));   // SOS
        send_item(make_item(REQ_SAMPLE, 2500, 1'b1));    // between limits
        send_item(make_item(REQ_SAMPLE, 3500, 1'b1));    // equal to high: no force
        send_item(make_item(REQ_SAMPLE, 1500, 1'b1));    // equal to low: no force
        send_item(make_item(REQ_SAMPLE, 3501, 1'b1));
        send_item(make_item(REQ_SAMPLE, 1499, 1'b1));
        drain();

        // --- zero window length behaves as a window of one
        write_reg(CFG_WINDOW_LEN, 16'd0);
        send_item(make_item(REQ_SAMPLE, 0, 1'b1));
        send_item(make_item(REQ_SAMPLE, 16384, 1'b1));
        drain();

        // --- start_mode writes restart at once, spare codes included
        write_reg(CFG_START_MODE, 16'(MODE_OFF));
        send_item(make_item(REQ_TICK, 0, 1'b0));
        drain();
        write_reg(CFG_START_MODE, 16'(MODE_SPARE_LO));
        send_item(make_item(REQ_TICK, 0, 1'b0));
        drain();
        write_reg(CFG_START_MODE, 16'(MODE_SPARE_HI));
        send_item(make_item(REQ_TICK, 0, 1'b0));
        drain();

        // --- random, sender idles rarely, receiver stalls a lot
        // heartbeat held (advance far away), no forcing possible
        setup(1023, 1, 20000, -5000, MODE_HEARTBEAT);
        run_random(265);
        // advance on every expiry; widest window with random limits
        setup(0, 63, int'($urandom_range(25000)) - 5000,
              int'($urandom_range(25000)) - 5000, NO_START);
        run_random(265);

        // --- sender idles a lot, receiver rarely
        src_idle_pct  = 67;
        snk_stall_pct = 7;
        setup(1, 0, int'(RST_HIGH_AVG), int'(RST_LOW_AVG), NO_START);
        run_random(265);
        setup(2, 2, 20000, -5000, MODE_SPARE_LO);
        run_random(265);

        // --- back to back, no idling at all
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        // crossed limits: nearly every window forces fast blink
        setup(1023, 4, -5000, 20000, MODE_SPARE_HI);
        run_random(265);
        setup(int'($urandom_range(1, 8)), int'($urandom_range(1, 8)),
              int'($urandom_range(25000)) - 5000, int'($urandom_range(25000)) - 5000,
              int'($urandom_range(5)));
        run_random(265);

        drain();
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== led_pattern_sequencer_core.f =====
src/lps_pkg.sv
src/lps_cfg_regs.sv
src/lps_update.sv
src/led_pattern_sequencer_core.sv
test/tb_led_pattern_sequencer_core.sv
